// ===== sv/cartridge_image_checker_core_defines.svh =====
// ---------------------------------------------------------------------------
// Cartridge image checker assertion macros
// Shared property wrappers clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef CARTRIDGE_IMAGE_CHECKER_CORE_DEFINES_SVH
`define CARTRIDGE_IMAGE_CHECKER_CORE_DEFINES_SVH

// condition must hold at every edge
`define CIC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// same-cycle implication
`define CIC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/cic_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cic_pkg
// Types and constants shared by the cartridge image checker modules.
// ---------------------------------------------------------------------------
package cic_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned CRC_W    = 32;
    localparam int unsigned LEN_W    = 24;
    localparam int unsigned EXP_W    = 23;
    localparam int unsigned M_DATA_W = 88;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [LEN_W-1:0] LEN_MAX  = 24'hFFFFFF;

    localparam int unsigned HDR_LEN   = 16;
    localparam int unsigned IDX_MAG0  = 0;
    localparam int unsigned IDX_MAG1  = 1;
    localparam int unsigned IDX_MAG2  = 2;
    localparam int unsigned IDX_MAG3  = 3;
    localparam int unsigned IDX_PROG  = 4;
    localparam int unsigned IDX_PAT   = 5;
    localparam int unsigned IDX_FLG6  = 6;
    localparam int unsigned IDX_FLG7  = 7;

    localparam logic [DATA_W-1:0] MAGIC0 = 8'h4E;
    localparam logic [DATA_W-1:0] MAGIC1 = 8'h45;
    localparam logic [DATA_W-1:0] MAGIC2 = 8'h53;
    localparam logic [DATA_W-1:0] MAGIC3 = 8'h1A;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [1:0] STATUS_BAD_SIZE  = 2'd2;
    localparam logic [1:0] STATUS_UNUSED    = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              last_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [7:0]        program_banks;
        logic [7:0]        pattern_banks;
        logic              vertical_mirror;
        logic [7:0]        mapper_number;
        logic              pattern_is_ram;
        logic [CRC_W-1:0]  body_crc;
        logic [LEN_W-1:0]  image_length;
    } result_t;

endpackage

// ===== sv/cic_input_stage.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cic_input_stage
// Input word register; refills whenever the held word is consumed.
// ---------------------------------------------------------------------------
module cic_input_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,
    input  logic              take,
    output logic              word_valid,
    output cic_pkg::in_word_t word
);
    import cic_pkg::*;

    logic     valid_reg;
    in_word_t word_reg;

    assign s_tready   = !valid_reg || take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            word_reg.data_byte <= s_tdata;
            word_reg.last_byte <= s_tlast;
        end
    end

endmodule

// ===== sv/cic_crc_byte.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cic_crc_byte
// Reflected CRC-32 update over one byte, unrolled eight bit steps.
// ---------------------------------------------------------------------------
module cic_crc_byte (
    input  logic [cic_pkg::CRC_W-1:0]  crc_in,
    input  logic [cic_pkg::DATA_W-1:0] data_in,
    output logic [cic_pkg::CRC_W-1:0]  crc_out
);
    import cic_pkg::*;

    always_comb begin
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, data_in};
        for (int k = 0; k < DATA_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        crc_out = c;
    end

endmodule

// ===== sv/cic_tracker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cic_tracker
// Byte counter, header capture, body CRC and end-of-image checks.
// ---------------------------------------------------------------------------
module cic_tracker #(
    parameter int COUNT_BITS = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              word_valid,
    input  cic_pkg::in_word_t word,
    input  logic              out_free,
    output logic              take,
    output logic              res_valid,
    output cic_pkg::result_t  res
);
    import cic_pkg::*;

    localparam int unsigned WIDE = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [CRC_W-1:0]      crc_reg, crc_next, crc_upd;
    logic                  magic_reg, magic_next;
    logic [7:0]            prog_reg, prog_next;
    logic [7:0]            pat_reg, pat_next;
    logic [7:0]            flg_lo_reg, flg_lo_next;
    logic [3:0]            flg_hi_reg, flg_hi_next;
    logic [EXP_W-1:0]      expect_len;
    logic [WIDE-1:0]       len_wide;
    logic [DATA_W-1:0]     b;

    assign b    = word.data_byte;
    assign take = word_valid && (!word.last_byte || out_free);

    cic_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (b),
        .crc_out (crc_upd)
    );

    always_comb begin
        count_next  = count_reg;
        crc_next    = crc_reg;
        magic_next  = magic_reg;
        prog_next   = prog_reg;
        pat_next    = pat_reg;
        flg_lo_next = flg_lo_reg;
        flg_hi_next = flg_hi_reg;
        res_valid   = 1'b0;

        if (take) begin
            if (count_reg == COUNT_BITS'(IDX_MAG0) && b != MAGIC0) magic_next = 1'b0;
            if (count_reg == COUNT_BITS'(IDX_MAG1) && b != MAGIC1) magic_next = 1'b0;
            if (count_reg == COUNT_BITS'(IDX_MAG2) && b != MAGIC2) magic_next = 1'b0;
            if (count_reg == COUNT_BITS'(IDX_MAG3) && b != MAGIC3) magic_next = 1'b0;
            if (count_reg == COUNT_BITS'(IDX_PROG)) prog_next   = b;
            if (count_reg == COUNT_BITS'(IDX_PAT))  pat_next    = b;
            if (count_reg == COUNT_BITS'(IDX_FLG6)) flg_lo_next = b;
            if (count_reg == COUNT_BITS'(IDX_FLG7)) flg_hi_next = b[7:4];
            if (count_reg >= COUNT_BITS'(HDR_LEN))  crc_next    = crc_upd;
            if (count_reg != CNT_MAX)               count_next  = count_reg + 1'b1;
            res_valid = word.last_byte;
        end

        expect_len = {1'b0, prog_next, 14'b0} + {2'b0, pat_next, 13'b0}
                   + EXP_W'(HDR_LEN);
        len_wide   = WIDE'(count_next);

        if (count_next < COUNT_BITS'(HDR_LEN) || !magic_next) begin
            res.status = STATUS_BAD_MAGIC;
        end else if (count_next == CNT_MAX || count_next != COUNT_BITS'(expect_len)
                     || prog_next == 8'd0) begin
            res.status = STATUS_BAD_SIZE;
        end else begin
            res.status = STATUS_OK;
        end
        res.program_banks   = prog_next;
        res.pattern_banks   = pat_next;
        res.vertical_mirror = flg_lo_next[0];
        res.mapper_number   = {flg_hi_next, flg_lo_next[7:4]};
        res.pattern_is_ram  = (pat_next == 8'd0);
        res.body_crc        = ~crc_next;
        res.image_length    = (len_wide > WIDE'(LEN_MAX)) ? LEN_MAX : LEN_W'(len_wide);

        // image done: back to reset state
        if (res_valid) begin
            count_next  = '0;
            crc_next    = CRC_INIT;
            magic_next  = 1'b1;
            prog_next   = 8'd0;
            pat_next    = 8'd0;
            flg_lo_next = 8'd0;
            flg_hi_next = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            crc_reg    <= CRC_INIT;
            magic_reg  <= 1'b1;
            prog_reg   <= 8'd0;
            pat_reg    <= 8'd0;
            flg_lo_reg <= 8'd0;
            flg_hi_reg <= 4'd0;
        end else begin
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            magic_reg  <= magic_next;
            prog_reg   <= prog_next;
            pat_reg    <= pat_next;
            flg_lo_reg <= flg_lo_next;
            flg_hi_reg <= flg_hi_next;
        end
    end

endmodule

// ===== sv/cartridge_image_checker_core.sv =====
`timescale 1ns / 1ps
// m_tvalid is registered: the input register loads the last word at the edge that
// accepts it, and the result register loads once the output is free.
// Throughput: one word per cycle, but a last word waits while a result is unread;
// the byte-wide CRC and size compare sit in one stage between input and result regs.
// Reset: synchronous, active low; clears counter, CRC, header fields, valids.
// After each last word the tracking state returns to its reset values.
// ---------------------------------------------------------------------------
// cartridge_image_checker_core
// Streams an image byte by byte, checks header and size, CRCs the body.
// ---------------------------------------------------------------------------
`include "cartridge_image_checker_core_defines.svh"

module cartridge_image_checker_core #(
    parameter int COUNT_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // [1:0] status, [9:2] program_banks,
                                   // [17:10] pattern_banks, [18] vertical_mirror,
                                   // [26:19] mapper_number, [27] pattern_is_ram,
                                   // [59:28] body_crc, [83:60] image_length, [87:84] 0
);
    import cic_pkg::*;

    in_word_t             word;
    logic                 word_valid;
    logic                 take;
    logic                 out_free;
    logic                 res_valid;
    result_t              res;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic [1:0]           m_status;
    logic [7:0]           m_prog;
    logic [7:0]           m_pat;
    logic                 m_ram;
    logic                 m_ok;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign m_status = m_tdata_reg[1:0];
    assign m_prog   = m_tdata_reg[9:2];
    assign m_pat    = m_tdata_reg[17:10];
    assign m_ram    = m_tdata_reg[27];
    assign m_ok     = m_tvalid_reg && (m_status == STATUS_OK);

    cic_input_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    cic_tracker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_trk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_valid (word_valid),
        .word       (word),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= {4'b0, res.image_length, res.body_crc, res.pattern_is_ram,
                            res.mapper_number, res.vertical_mirror, res.pattern_banks,
                            res.program_banks, res.status};
        end
    end

    `CIC_ASSERT_IMPL(a_no_overwrite, m_tvalid_reg && !m_tready, !res_valid, "result overwritten")
    `CIC_ASSERT_IMPL(a_status_code, m_tvalid_reg, m_status != STATUS_UNUSED, "undefined status")
    `CIC_ASSERT_IMPL(a_ram_flag, m_tvalid_reg, m_ram == (m_pat == 8'd0), "pattern RAM flag mismatch")
    `CIC_ASSERT_IMPL(a_ok_has_prog, m_ok, m_prog != 8'd0, "ok status with zero program banks")

endmodule
